// File: design/psg_pkg.sv
`timescale 1ns / 1ps

package psg_pkg;

  // Width of the limit register and of the prime field.
  localparam int LIMIT_W = 17;
  localparam int PRIME_W = 16;

  // Default size of the sieve bitmap and the limit after reset.
  localparam int DEF_MAX_LIMIT = 65536;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT = 17'd65536;

  // The two primes kept out of the bitmap, and the first number that the bitmap serves.
  localparam int FIRST_PRIME  = 2;
  localparam int SECOND_PRIME = 3;
  localparam int FIRST_SIEVED = 5;

  // Quadratic form status handed from the form generator to the sequencer.
  typedef struct packed {
    logic       done;
    logic [2:0] hit;
  } psg_form_flags_t;

endpackage

// File: design/psg_forms.sv
`timescale 1ns / 1ps

module psg_forms import psg_pkg::*; #(
  parameter int MAX_LIMIT = DEF_MAX_LIMIT,
  localparam int AW = $clog2(MAX_LIMIT),
  localparam int LW = AW + 1
) (
  input  logic            clk,
  input  logic            start,
  input  logic            step,
  input  logic [LW-1:0]   lim,
  output psg_form_flags_t flags,
  output logic [AW-1:0]   n0,
  output logic [AW-1:0]   n1,
  output logic [AW-1:0]   n2
);

  localparam int XW = (AW + 1) / 2 + 1;
  localparam int SW = 2 * XW;
  localparam int NW = SW + 3;
  localparam logic [3:0] MOD_LAST = 4'd11;
  localparam logic [3:0] RES_A    = 4'd1;
  localparam logic [3:0] RES_B    = 4'd5;
  localparam logic [3:0] RES_C    = 4'd7;
  localparam logic [3:0] RES_D    = 4'd11;
  localparam logic [5:0] MODULUS  = 6'd12;

  // Square of a residue, modulo 12.
  function automatic logic [3:0] sq_mod12(input logic [3:0] m);
    logic [3:0] s;
    case (m)
      4'd1, 4'd5, 4'd7, 4'd11: s = 4'd1;
      4'd2, 4'd4, 4'd8, 4'd10: s = 4'd4;
      4'd3, 4'd9:              s = 4'd9;
      default:                 s = 4'd0;
    endcase
    return s;
  endfunction

  // Reduction modulo 12 of a small value below 48.
  function automatic logic [3:0] mod12_small(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int k = 0; k < 4; k++) begin
      if (t >= MODULUS) begin
        t = t - MODULUS;
      end
    end
    return t[3:0];
  endfunction

  logic [XW-1:0] x, y;
  logic [SW-1:0] x2, y2;
  logic [3:0]    xm, ym;
  logic [SW-1:0] x2_inc, y2_inc;
  logic [NW-1:0] x2e, y2e, lim_e, n0f, n1f, n2f;
  logic [3:0]    a, b, r0, r1, r2;

  // Squares of the next row and column.
  assign x2_inc = x2 + (SW'(x) << 1) + SW'(1);
  assign y2_inc = y2 + (SW'(y) << 1) + SW'(1);

  // Walk the (x, y) grid one pair per step, y inner.
  always_ff @(posedge clk) begin
    if (start) begin
      x  <= XW'(1);
      y  <= XW'(1);
      x2 <= SW'(1);
      y2 <= SW'(1);
      xm <= 4'd1;
      ym <= 4'd1;
    end else if (step) begin
      if (y2_inc < SW'(lim)) begin
        y  <= y + XW'(1);
        y2 <= y2_inc;
        ym <= (ym == MOD_LAST) ? 4'd0 : ym + 4'd1;
      end else begin
        y  <= XW'(1);
        y2 <= SW'(1);
        ym <= 4'd1;
        x  <= x + XW'(1);
        x2 <= x2_inc;
        xm <= (xm == MOD_LAST) ? 4'd0 : xm + 4'd1;
      end
    end
  end

  // The three forms and their values.
  assign x2e   = NW'(x2);
  assign y2e   = NW'(y2);
  assign lim_e = NW'(lim);
  assign n0f   = (x2e << 2) + y2e;
  assign n1f   = (x2e << 1) + x2e + y2e;
  assign n2f   = (x2e << 1) + x2e - y2e;

  // Residues modulo 12 come from the tracked residues of x and y.
  assign a  = sq_mod12(xm);
  assign b  = sq_mod12(ym);
  assign r0 = mod12_small(6'({a, 2'b00}) + 6'(b));
  assign r1 = mod12_small(6'({a, 1'b0}) + 6'(a) + 6'(b));
  assign r2 = mod12_small(6'({a, 1'b0}) + 6'(a) + MODULUS - 6'(b));

  always_comb begin
    flags.hit[0] = (n0f < lim_e) && (r0 inside {RES_A, RES_B});
    flags.hit[1] = (n1f < lim_e) && (r1 == RES_C);
    flags.hit[2] = (x > y) && (n2f < lim_e) && (r2 == RES_D);
    flags.done   = (lim_e <= NW'(1)) || (x2e >= lim_e);
  end

  assign n0 = n0f[AW-1:0];
  assign n1 = n1f[AW-1:0];
  assign n2 = n2f[AW-1:0];

endmodule

// File: design/prime_sieve_generator_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   restart
// output    out        out_valid / out_stall prime, found
// config    in         cfg_write             cfg_data (sieve limit)
//
// A request without a build scans one candidate per cycle from the last prime to the
// next one; the first read is issued in S_SCAN0 from the registered bitmap port.
// A build (restart, or the first request) clears the bitmap below the limit, checks
// each form of each (x, y) pair with x*x and y*y below the limit, reading a hit in
// S_TOG and toggling it in S_TOGW, then clears multiples of r*r, one entry a cycle.
// Reset is synchronous; the bitmap has no reset and is cleared below the limit by every build.
// Input stalls while a transaction is in work; a stalled result holds the block.

module prime_sieve_generator_unit import psg_pkg::*; #(
  parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PRIME_W-1:0] prime,
  output logic               found
);

  localparam int AW = $clog2(MAX_LIMIT);
  localparam int LW = AW + 1;
  localparam int XW = (AW + 1) / 2 + 1;
  localparam int SW = 2 * XW;
  localparam int EW = (LW > LIMIT_W) ? LW : LIMIT_W;
  localparam int PW = (LW > PRIME_W) ? LW : PRIME_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_TOG   = 4'd2;
  localparam logic [3:0] S_TOGW  = 4'd3;
  localparam logic [3:0] S_SQRD  = 4'd4;
  localparam logic [3:0] S_SQCHK = 4'd5;
  localparam logic [3:0] S_SQCLR = 4'd6;
  localparam logic [3:0] S_SCAN0 = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]         state;
  logic [LIMIT_W-1:0] sieve_limit;
  logic [LW-1:0]      lim;
  logic [LW-1:0]      build_lim;
  logic [LW-1:0]      next_candidate;
  logic               sieve_ready;
  logic [LW-1:0]      clr_addr;
  logic [1:0]         form_sel;
  logic [XW-1:0]      r;
  logic [SW-1:0]      r2;
  logic [LW:0]        clr_ptr;
  logic [LW-1:0]      pend;
  logic [PRIME_W-1:0] res_prime;
  logic               res_found;

  // Bitmap and its ports.
  logic               mem [MAX_LIMIT];
  logic               mem_we, mem_re, mem_wdata, mem_rdata;
  logic [AW-1:0]      mem_waddr, mem_raddr;

  // Form generator interface.
  psg_form_flags_t    form_flags;
  logic [AW-1:0]      n0, n1, n2, n_sel;
  logic               hit_sel, form_start, form_step;

  // Handy terms.
  logic               accept, build, out_free;
  logic [LW:0]        clr_next;
  logic               clr_last, r2_lt, ptr_lt, cand_lt, nxt_lt, is_prime;
  logic [LW-1:0]      nxt;
  logic [PW-1:0]      pend_ext;

  // Effective limit: the register saturated to the bitmap size.
  assign lim = (EW'(sieve_limit) > EW'(MAX_LIMIT)) ? LW'(MAX_LIMIT) : LW'(sieve_limit);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign build    = restart || !sieve_ready;
  assign out_free = !out_valid || !out_stall;

  assign clr_next = {1'b0, clr_addr} + (LW + 1)'(1);
  assign clr_last = (clr_next >= (LW + 1)'(lim));
  assign r2_lt    = (r2 < SW'(lim));
  assign ptr_lt   = (clr_ptr < (LW + 1)'(lim));
  assign cand_lt  = (next_candidate < lim);
  assign nxt      = pend + LW'(1);
  assign nxt_lt   = (nxt < lim);
  assign pend_ext = PW'(pend);

  assign is_prime = (pend == LW'(FIRST_PRIME)) || (pend == LW'(SECOND_PRIME)) ||
                    ((pend >= LW'(FIRST_SIEVED)) && (pend < build_lim) && mem_rdata);

  // Form currently handled for this (x, y) pair.
  always_comb begin
    case (form_sel)
      2'd0:    n_sel = n0;
      2'd1:    n_sel = n1;
      default: n_sel = n2;
    endcase
  end
  assign hit_sel = form_flags.hit[form_sel];

  psg_forms #(
    .MAX_LIMIT(MAX_LIMIT)
  ) u_forms (
    .clk  (clk),
    .start(form_start),
    .step (form_step),
    .lim  (lim),
    .flags(form_flags),
    .n0   (n0),
    .n1   (n1),
    .n2   (n2)
  );

  // Start the grid walk after the clear, or at once for an empty range.
  assign form_start = (state == S_CLEAR && clr_last) ||
                      (accept && build && lim == '0);
  assign form_step  = (form_sel == 2'd2) &&
                      ((state == S_TOG && !form_flags.done && !hit_sel) ||
                       (state == S_TOGW));

  // Memory port control per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = 1'b0;
    mem_waddr = clr_addr[AW-1:0];
    mem_raddr = n_sel;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_TOG: begin
        mem_re = !form_flags.done && hit_sel;
      end
      S_TOGW: begin
        mem_we    = 1'b1;
        mem_waddr = n_sel;
        mem_wdata = ~mem_rdata;
      end
      S_SQRD: begin
        mem_re    = r2_lt;
        mem_raddr = AW'(r);
      end
      S_SQCLR: begin
        mem_we    = ptr_lt;
        mem_waddr = clr_ptr[AW-1:0];
      end
      S_SCAN0: begin
        mem_re    = cand_lt;
        mem_raddr = next_candidate[AW-1:0];
      end
      S_SCAN: begin
        mem_re    = !is_prime && nxt_lt;
        mem_raddr = nxt[AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Bitmap storage with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit <= RESET_LIMIT;
    end else if (cfg_write) begin
      sieve_limit <= cfg_data;
    end
  end

  // Sequencer: build, toggle, square clearing, scan, result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      next_candidate <= LW'(FIRST_PRIME);
      sieve_ready    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (restart) begin
              next_candidate <= LW'(FIRST_PRIME);
            end
            if (build) begin
              build_lim <= lim;
              clr_addr  <= '0;
              form_sel  <= 2'd0;
              state     <= (lim == '0) ? S_TOG : S_CLEAR;
            end else begin
              state <= S_SCAN0;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_next[LW-1:0];
          if (clr_last) begin
            state <= S_TOG;
          end
        end
        S_TOG: begin
          if (form_flags.done) begin
            r     <= XW'(FIRST_SIEVED);
            r2    <= SW'(FIRST_SIEVED * FIRST_SIEVED);
            state <= S_SQRD;
          end else if (hit_sel) begin
            state <= S_TOGW;
          end else begin
            form_sel <= (form_sel == 2'd2) ? 2'd0 : form_sel + 2'd1;
          end
        end
        S_TOGW: begin
          form_sel <= (form_sel == 2'd2) ? 2'd0 : form_sel + 2'd1;
          state    <= S_TOG;
        end
        S_SQRD: begin
          if (r2_lt) begin
            state <= S_SQCHK;
          end else begin
            sieve_ready <= 1'b1;
            state       <= S_SCAN0;
          end
        end
        S_SQCHK: begin
          if (mem_rdata) begin
            clr_ptr <= (LW + 1)'(r2);
            state   <= S_SQCLR;
          end else begin
            r     <= r + XW'(1);
            r2    <= r2 + (SW'(r) << 1) + SW'(1);
            state <= S_SQRD;
          end
        end
        S_SQCLR: begin
          if (ptr_lt) begin
            clr_ptr <= clr_ptr + (LW + 1)'(r2);
          end else begin
            r     <= r + XW'(1);
            r2    <= r2 + (SW'(r) << 1) + SW'(1);
            state <= S_SQRD;
          end
        end
        S_SCAN0: begin
          if (cand_lt) begin
            pend  <= next_candidate;
            state <= S_SCAN;
          end else begin
            res_prime <= '0;
            res_found <= 1'b0;
            state     <= S_FIN;
          end
        end
        S_SCAN: begin
          if (is_prime) begin
            res_prime      <= pend_ext[PRIME_W-1:0];
            res_found      <= 1'b1;
            next_candidate <= nxt;
            state          <= S_FIN;
          end else if (nxt_lt) begin
            pend <= nxt;
          end else begin
            res_prime      <= '0;
            res_found      <= 1'b0;
            next_candidate <= nxt;
            state          <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            prime     <= res_prime;
            found     <= res_found;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A finished build always leaves the sieve marked ready.
  a_build_ready : assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRD && !r2_lt) |=> sieve_ready)
    else $error("build finished without marking the sieve ready");

  // Bitmap writes stay below the limit of the build in progress.
  a_write_range : assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ({1'b0, mem_waddr} < build_lim))
    else $error("bitmap write beyond the build limit");

  // The candidate under test always lies below the limit.
  a_scan_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pend < lim))
    else $error("scan candidate at or above the limit");

  // An exhausted result carries a zero prime.
  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (prime == '0))
    else $error("nonzero prime on an exhausted result");

endmodule
